[src/mm2h_pkg.sv]
// Shared types, constants and helpers for the MurmurHash2 word stream hash unit.
// Used by mm2h_ctrl, mm2h_datapath and the top level; depends on nothing.
package mm2h_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int unsigned MIX_SHIFT   = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIXA,
    ST_MIXB,
    ST_FOLD,
    ST_TAIL,
    ST_FINA,
    ST_FINB
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MIXA,
    OP_MIXB,
    OP_FOLD,
    OP_TAIL,
    OP_FINA,
    OP_FINB
  } dp_op_t;

  typedef struct packed {
    logic   load;
    logic   use_len;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic new_last;
    logic new_full;
    logic new_zero;
    logic cur_last;
    logic out_busy;
  } dp_sts_t;

  function automatic logic [31:0] tail_mask(input logic [1:0] cnt);
    logic [31:0] m;
    case (cnt)
      2'd1:    m = 32'h0000_00ff;
      2'd2:    m = 32'h0000_ffff;
      2'd3:    m = 32'h00ff_ffff;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage

[src/murmur2_word_stream_hash_unit.sv]
// MurmurHash2 (32-bit) over a stream of little-endian words; top level.
// Non-last word: MIXA, MIXB, FOLD, then ready. Last full word: MIXA, MIXB,
// FOLD, FINA, FINB; tail: TAIL, FINA, FINB; empty: FINA, FINB to the result.
// One shared 32x32 constant multiplier: one step per cycle unless FINB stalls.
// Synchronous active-high reset returns to idle, expecting a first word.
// Instantiates mm2h_ctrl and mm2h_datapath; uses mm2h_pkg.
module murmur2_word_stream_hash_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last,
  input  logic [31:0] total_length,
  output logic        hash_valid,
  input  logic        hash_ready,
  output logic [31:0] hash_value
);

  mm2h_pkg::dp_cmd_t cmd;
  mm2h_pkg::dp_sts_t sts;

  mm2h_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mm2h_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .data_word    (data_word),
    .byte_count   (byte_count),
    .last         (last),
    .total_length (total_length),
    .cmd          (cmd),
    .sts          (sts),
    .hash_value   (hash_value),
    .hash_valid   (hash_valid),
    .hash_ready   (hash_ready)
  );

endmodule

[src/mm2h_ctrl.sv]
// Sequencer for the MurmurHash2 word stream hash unit.
// Drives mm2h_datapath through dp_cmd_t; uses mm2h_pkg.
module mm2h_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  mm2h_pkg::dp_sts_t sts,
  output mm2h_pkg::dp_cmd_t cmd
);

  mm2h_pkg::state_t state;
  mm2h_pkg::state_t state_next;
  logic             in_message;
  logic             in_message_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mm2h_pkg::ST_IDLE;
      in_message <= 1'b0;
    end else begin
      state      <= state_next;
      in_message <= in_message_next;
    end
  end

  always_comb begin
    state_next      = state;
    in_message_next = in_message;
    case (state)
      mm2h_pkg::ST_IDLE: begin
        if (item_valid) begin
          if (!sts.new_last || sts.new_full) begin
            state_next = mm2h_pkg::ST_MIXA;
          end else if (sts.new_zero) begin
            state_next = mm2h_pkg::ST_FINA;
          end else begin
            state_next = mm2h_pkg::ST_TAIL;
          end
        end
      end
      mm2h_pkg::ST_MIXA: state_next = mm2h_pkg::ST_MIXB;
      mm2h_pkg::ST_MIXB: state_next = mm2h_pkg::ST_FOLD;
      mm2h_pkg::ST_FOLD: begin
        if (sts.cur_last) begin
          state_next = mm2h_pkg::ST_FINA;
        end else begin
          state_next      = mm2h_pkg::ST_IDLE;
          in_message_next = 1'b1;
        end
      end
      mm2h_pkg::ST_TAIL: state_next = mm2h_pkg::ST_FINA;
      mm2h_pkg::ST_FINA: state_next = mm2h_pkg::ST_FINB;
      mm2h_pkg::ST_FINB: begin
        if (!sts.out_busy) begin
          state_next      = mm2h_pkg::ST_IDLE;
          in_message_next = 1'b0;
        end
      end
      default: state_next = mm2h_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready  = 1'b0;
    cmd.load    = 1'b0;
    cmd.use_len = !in_message;
    cmd.op      = mm2h_pkg::OP_NONE;
    case (state)
      mm2h_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        cmd.load   = item_valid;
      end
      mm2h_pkg::ST_MIXA: cmd.op = mm2h_pkg::OP_MIXA;
      mm2h_pkg::ST_MIXB: cmd.op = mm2h_pkg::OP_MIXB;
      mm2h_pkg::ST_FOLD: cmd.op = mm2h_pkg::OP_FOLD;
      mm2h_pkg::ST_TAIL: cmd.op = mm2h_pkg::OP_TAIL;
      mm2h_pkg::ST_FINA: cmd.op = mm2h_pkg::OP_FINA;
      mm2h_pkg::ST_FINB: begin
        if (!sts.out_busy) begin
          cmd.op = mm2h_pkg::OP_FINB;
        end
      end
      default: cmd.op = mm2h_pkg::OP_NONE;
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> (state != mm2h_pkg::ST_IDLE))
    else $error("accepted request did not start processing");

  a_finb_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == mm2h_pkg::OP_FINB) |-> !sts.out_busy)
    else $error("result written while output register occupied");

  a_finish_ends_message: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == mm2h_pkg::OP_FINB) |=> (!in_message && state == mm2h_pkg::ST_IDLE))
    else $error("message state not cleared after result");

  a_fold_nonlast_opens: assert property (@(posedge clk) disable iff (rst)
    (state == mm2h_pkg::ST_FOLD && !sts.cur_last) |=> in_message)
    else $error("message not opened after non-last word");

endmodule

[src/mm2h_datapath.sv]
// Datapath for the MurmurHash2 word stream hash unit: item registers, one shared
// constant multiplier, running hash and output register. Uses mm2h_pkg.
module mm2h_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       data_word,
  input  logic [2:0]        byte_count,
  input  logic              last,
  input  logic [31:0]       total_length,
  input  mm2h_pkg::dp_cmd_t cmd,
  output mm2h_pkg::dp_sts_t sts,
  output logic [31:0]       hash_value,
  output logic              hash_valid,
  input  logic              hash_ready
);

  logic [31:0] word_q;
  logic [1:0]  count_q;
  logic        last_q;
  logic [31:0] k;
  logic [31:0] h;
  logic [31:0] mul_a;
  logic [31:0] mul_p;

  always_comb begin
    case (cmd.op)
      mm2h_pkg::OP_MIXA: mul_a = word_q;
      mm2h_pkg::OP_MIXB: mul_a = k;
      mm2h_pkg::OP_FOLD: mul_a = h;
      mm2h_pkg::OP_TAIL: mul_a = h ^ (word_q & mm2h_pkg::tail_mask(count_q));
      mm2h_pkg::OP_FINA: mul_a = h ^ (h >> mm2h_pkg::FIN_SHIFT_A);
      default:           mul_a = h;
    endcase
  end

  assign mul_p = mul_a * mm2h_pkg::MIX_MUL;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_q  <= data_word;
      count_q <= byte_count[1:0];
      last_q  <= last;
      if (cmd.use_len) begin
        h <= total_length;
      end
    end
    case (cmd.op)
      mm2h_pkg::OP_MIXA: k <= mul_p ^ (mul_p >> mm2h_pkg::MIX_SHIFT);
      mm2h_pkg::OP_MIXB: k <= mul_p;
      mm2h_pkg::OP_FOLD: h <= mul_p ^ k;
      mm2h_pkg::OP_TAIL: h <= mul_p;
      mm2h_pkg::OP_FINA: h <= mul_p;
      mm2h_pkg::OP_FINB: hash_value <= h ^ (h >> mm2h_pkg::FIN_SHIFT_B);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_valid <= 1'b0;
    end else if (cmd.op == mm2h_pkg::OP_FINB) begin
      hash_valid <= 1'b1;
    end else if (hash_ready) begin
      hash_valid <= 1'b0;
    end
  end

  assign sts.new_last = last;
  assign sts.new_full = byte_count[2];
  assign sts.new_zero = (byte_count == 3'd0);
  assign sts.cur_last = last_q;
  assign sts.out_busy = hash_valid && !hash_ready;

endmodule

[dv/tb_murmur2_word_stream_hash_unit.sv]
// Testbench for murmur2_word_stream_hash_unit: drives word streams with random idling on
// both handshakes and checks every hash against an in-bench MurmurHash2 predictor.
// Depends only on the RTL under src/ (instantiates the top level only).
module tb_murmur2_word_stream_hash_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] MURMUR_M = 32'h5bd1e995;
  localparam int          GAP_MAX  = 18;

  logic        clk;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [31:0] data_word = '0;
  logic [2:0]  byte_count = '0;
  logic        last = 1'b0;
  logic [31:0] total_length = '0;
  logic        hash_valid;
  logic        hash_ready = 1'b0;
  logic [31:0] hash_value;

  logic [31:0] pending_hashes[$];
  logic [31:0] seed_hash = '0;
  logic        mid_message = 1'b0;
  int          req_gap_max = 0;
  int          rsp_gap_max = 0;
  int          failures = 0;
  int          words_taken = 0;
  int          hashes_seen = 0;
  int          messages_sent = 0;

  murmur2_word_stream_hash_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .data_word    (data_word),
    .byte_count   (byte_count),
    .last         (last),
    .total_length (total_length),
    .hash_valid   (hash_valid),
    .hash_ready   (hash_ready),
    .hash_value   (hash_value)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [31:0] mix_word32(input logic [31:0] k);
    logic [31:0] t;
    t = k * MURMUR_M;
    t = t ^ (t >> 24);
    t = t * MURMUR_M;
    return t;
  endfunction

  function automatic logic [31:0] fold_word32(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] t;
    t = h * MURMUR_M;
    return t ^ mix_word32(w);
  endfunction

  function automatic logic [31:0] avalanche32(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 13);
    t = t * MURMUR_M;
    return t ^ (t >> 15);
  endfunction

  // hash checker and predictor, both sampled at the rising edge
  always @(posedge clk) begin : hash_scoreboard
    logic [31:0] h;
    logic [31:0] want;
    int unsigned nbytes;
    if (!rst) begin
      if (hash_valid && hash_ready) begin
        hashes_seen++;
        if (pending_hashes.size() == 0) begin
          failures++;
          $display("%0t: unexpected hash, expected none, actual %08h", $time, hash_value);
        end else begin
          want = pending_hashes.pop_front();
          if (hash_value !== want) begin
            failures++;
            $display("%0t: hash_value mismatch, expected %08h, actual %08h",
                     $time, want, hash_value);
          end
        end
      end
      if (item_valid && item_ready) begin
        words_taken++;
        h = mid_message ? seed_hash : total_length;
        if (!last) begin
          seed_hash = fold_word32(h, data_word);
          mid_message = 1'b1;
        end else begin
          nbytes = (byte_count > 3'd4) ? 4 : byte_count;
          if (nbytes == 4) begin
            h = fold_word32(h, data_word);
          end else if (nbytes != 0) begin
            h = (h ^ (data_word & ((32'h1 << (8 * nbytes)) - 32'h1))) * MURMUR_M;
          end
          pending_hashes.push_back(avalanche32(h));
          seed_hash = '0;
          mid_message = 1'b0;
        end
      end
    end
  end

  // result side: random stall before each hash
  initial begin : hash_sink
    int stall;
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, rsp_gap_max);
      if (stall > 0) begin
        hash_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      hash_ready <= 1'b1;
      @(posedge clk);
      while (!(hash_valid === 1'b1)) @(posedge clk);
    end
  end

  // returns at the edge the request is taken; valid stays high until the next call or drain
  task automatic send_word(input logic [31:0] d, input logic [2:0] c, input logic l,
                           input logic [31:0] n);
    int gap;
    gap = $urandom_range(0, req_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    data_word    <= d;
    byte_count   <= c;
    last         <= l;
    total_length <= n;
    item_valid   <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_message(input int nwords, input bit honest_len);
    logic [2:0]  tail_cnt;
    logic [31:0] len;
    int          used;
    tail_cnt = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
    used = (tail_cnt > 3'd4) ? 4 : tail_cnt;
    len = honest_len ? 32'(4 * (nwords - 1) + used) : $urandom;
    for (int i = 0; i < nwords; i++) begin
      if (i == nwords - 1)
        send_word($urandom, tail_cnt, 1'b1, (i == 0) ? len : $urandom);
      else
        send_word($urandom, 3'($urandom_range(0, 7)), 1'b0, (i == 0) ? len : $urandom);
    end
    messages_sent++;
  endtask

  task automatic pick_idling();
    case ($urandom_range(0, 3))
      0: begin req_gap_max = 0;       rsp_gap_max = 0;       end
      1: begin req_gap_max = GAP_MAX; rsp_gap_max = 0;       end
      2: begin req_gap_max = 0;       rsp_gap_max = GAP_MAX; end
      default: begin req_gap_max = GAP_MAX; rsp_gap_max = GAP_MAX; end
    endcase
  endtask

  // every byte count on one-word messages, length and data at extremes
  task automatic test_single_word();
    req_gap_max = GAP_MAX;
    rsp_gap_max = GAP_MAX;
    send_word(32'h0000_0000, 3'd0, 1'b1, 32'h0000_0000);
    send_word(32'hffff_ffff, 3'd1, 1'b1, 32'hffff_ffff);
    send_word(32'hffff_ffff, 3'd2, 1'b1, 32'h0000_0000);
    send_word(32'ha5a5_a5a5, 3'd3, 1'b1, 32'h0000_0003);
    send_word(32'hffff_ffff, 3'd4, 1'b1, 32'h0000_0004);
    send_word(32'h1234_5678, 3'd5, 1'b1, 32'hffff_ffff);
    send_word(32'h8765_4321, 3'd6, 1'b1, 32'h0000_0004);
    send_word(32'hffff_ffff, 3'd7, 1'b1, 32'h0000_0000);
    messages_sent += 8;
    drain();
  endtask

  // non-last counts ignored, masked tail bytes, empty tail, length mismatch
  task automatic test_short_messages();
    send_word(32'h0000_0000, 3'd0, 1'b0, 32'h0000_0008);
    send_word(32'hffff_ffff, 3'd4, 1'b1, 32'h0000_0000);
    send_word(32'hffff_ffff, 3'd7, 1'b0, 32'hffff_ffff);
    send_word(32'hdead_beef, 3'd0, 1'b1, 32'h0000_0123);
    send_word(32'h0102_0304, 3'd4, 1'b0, 32'h0000_000b);
    send_word(32'h0506_0708, 3'd2, 1'b0, 32'h0000_0055);
    send_word(32'hff0a_0b0c, 3'd3, 1'b1, 32'hffff_ffff);
    send_word(32'hcafe_f00d, 3'd4, 1'b0, 32'h0000_0005);
    send_word(32'h8000_0001, 3'd1, 1'b1, 32'h0000_0005);
    messages_sent += 4;
    drain();
  endtask

  task automatic test_back_to_back();
    req_gap_max = 0;
    rsp_gap_max = 0;
    for (int m = 0; m < 60; m++)
      send_message($urandom_range(1, 8), $urandom_range(0, 4) != 0);
    drain();
  endtask

  task automatic test_random_traffic();
    for (int m = 0; m < 200; m++) begin
      if (m % 20 == 0)
        pick_idling();
      send_message($urandom_range(1, 8), $urandom_range(0, 4) != 0);
    end
    drain();
  endtask

  task automatic test_long_messages();
    req_gap_max = GAP_MAX;
    rsp_gap_max = GAP_MAX;
    for (int m = 0; m < 4; m++)
      send_message(40, 1'b1);
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_single_word();
    test_short_messages();
    test_back_to_back();
    test_random_traffic();
    test_long_messages();
    $display("Covered %0d messages / %0d word requests, %0d hashes compared, %0d failures.",
             messages_sent, words_taken, hashes_seen, failures);
    if (failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #4ms;
    $display("Timed out with %0d hashes still pending.", pending_hashes.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[filelist.f]
src/mm2h_pkg.sv
src/mm2h_ctrl.sv
src/mm2h_datapath.sv
src/murmur2_word_stream_hash_unit.sv
dv/tb_murmur2_word_stream_hash_unit.sv
